// ===== src/mhd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mhd_pkg
// Shared types, constants and the arctangent table for the heading block.
// ----------------------------------------------------------------------------
package mhd_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int STEP_W       = $clog2(CORDIC_STEPS);

  localparam int BYTE_W   = 8;
  localparam int AXIS_W   = 16;
  localparam int HEAD_W   = 15;
  localparam int FRAME_W  = 40;
  localparam int POS_W    = 3;
  localparam int VEC_W    = 27;
  localparam int ANG_W    = 25;
  localparam int SCALE_SH = 8;

  localparam logic [POS_W-1:0] LAST_POS = POS_W'(5);

  localparam logic signed [ANG_W-1:0] ANG_180 = ANG_W'(2949120);
  localparam logic signed [ANG_W-1:0] ANG_360 = ANG_W'(5898240);
  localparam logic signed [ANG_W-1:0] ANG_RND = ANG_W'(128);
  localparam logic [AXIS_W-1:0]       HEAD_FULL = AXIS_W'(23040);

  typedef logic signed [VEC_W-1:0] vec_t;
  typedef logic signed [ANG_W-1:0] ang_t;
  typedef logic [STEP_W-1:0]       step_t;

  typedef struct packed {
    logic  accept;
    logic  step;
    logic  finish;
    logic  emit;
    step_t idx;
  } cmd_t;

  typedef struct packed {
    logic last;
  } sts_t;

  // atan(2^-i) in 2^-14 degree
  function automatic ang_t atan_lut(input logic [4:0] i);
    ang_t v;
    case (i)
      5'd0:    v = ANG_W'(737280);
      5'd1:    v = ANG_W'(435242);
      5'd2:    v = ANG_W'(229970);
      5'd3:    v = ANG_W'(116736);
      5'd4:    v = ANG_W'(58595);
      5'd5:    v = ANG_W'(29326);
      5'd6:    v = ANG_W'(14667);
      5'd7:    v = ANG_W'(7334);
      5'd8:    v = ANG_W'(3667);
      5'd9:    v = ANG_W'(1833);
      5'd10:   v = ANG_W'(917);
      5'd11:   v = ANG_W'(458);
      5'd12:   v = ANG_W'(229);
      5'd13:   v = ANG_W'(115);
      5'd14:   v = ANG_W'(57);
      5'd15:   v = ANG_W'(29);
      5'd16:   v = ANG_W'(14);
      5'd17:   v = ANG_W'(7);
      5'd18:   v = ANG_W'(4);
      5'd19:   v = ANG_W'(2);
      5'd20:   v = ANG_W'(1);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ===== src/mhd_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mhd_ctrl
// Sequencer: byte intake, CORDIC step count, heading finish and result hand-off.
// ----------------------------------------------------------------------------
module mhd_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  input  mhd_pkg::sts_t sts_i,
  output mhd_pkg::cmd_t cmd_o
);
  import mhd_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FIN,
    ST_EMIT
  } state_e;

  state_e state_q;
  step_t  idx_q;
  logic   out_valid_q;
  logic   accept;
  logic   slot_free;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign accept      = in_valid_i && (state_q == ST_IDLE);
  assign slot_free   = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o        = '0;
    cmd_o.accept = accept;
    cmd_o.step   = (state_q == ST_RUN);
    cmd_o.finish = (state_q == ST_FIN);
    cmd_o.emit   = (state_q == ST_EMIT) && slot_free;
    cmd_o.idx    = idx_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if ((state_q == ST_EMIT) && slot_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          idx_q <= '0;
          if (accept && sts_i.last) begin
            state_q <= ST_RUN;
          end
        end
        ST_RUN: begin
          idx_q <= idx_q + 1'b1;
          if (idx_q == STEP_W'(CORDIC_STEPS - 1)) begin
            state_q <= ST_FIN;
          end
        end
        ST_FIN: begin
          state_q <= ST_EMIT;
        end
        ST_EMIT: begin
          if (slot_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== src/mhd_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mhd_dp
// Datapath: frame assembly, shared CORDIC vectoring stage, deadband filter
// and result registers.
// ----------------------------------------------------------------------------
module mhd_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  mhd_pkg::cmd_t                     cmd_i,
  output mhd_pkg::sts_t                     sts_o,
  input  logic [mhd_pkg::BYTE_W-1:0]        data_byte_i,
  input  logic                              frame_start_i,
  input  logic                              cfg_we_i,
  input  logic [mhd_pkg::HEAD_W-1:0]        cfg_data_i,
  output logic signed [mhd_pkg::AXIS_W-1:0] mag_x_o,
  output logic signed [mhd_pkg::AXIS_W-1:0] mag_y_o,
  output logic signed [mhd_pkg::AXIS_W-1:0] mag_z_o,
  output logic [mhd_pkg::HEAD_W-1:0]        heading_new_o,
  output logic [mhd_pkg::HEAD_W-1:0]        heading_shown_o,
  output logic                              shown_changed_o
);
  import mhd_pkg::*;

  logic [POS_W-1:0]         pos_q, pos_eff;
  logic [FRAME_W-1:0]       frame_q;
  logic [5:0]               sh;
  logic [HEAD_W-1:0]        thr_q, shown_q, hn_q;
  logic signed [AXIS_W-1:0] ax_x_q, ax_y_q, ax_z_q;
  logic signed [AXIS_W-1:0] nx, ny;
  logic                     zero_q, launch;
  vec_t                     cx_q, cy_q, sx, sy, dx, dy;
  ang_t                     cz_q, zf, zr, ta;
  logic [AXIS_W-1:0]        hraw;
  logic [HEAD_W-1:0]        hfin, diff;

  assign pos_eff  = (frame_start_i || pos_q > LAST_POS) ? '0 : pos_q;
  assign sts_o.last = (pos_eff == LAST_POS);
  assign launch   = cmd_i.accept && sts_o.last;
  assign sh       = {3'(3'd4 - pos_eff), 3'b000};

  assign nx = ax_x_q;
  assign ny = ax_y_q;
  assign sx = -(vec_t'($signed(frame_q[39:24])) <<< SCALE_SH);
  assign sy = -(vec_t'($signed({frame_q[7:0], data_byte_i})) <<< SCALE_SH);

  // one vectoring step
  assign dx = cy_q >>> cmd_i.idx;
  assign dy = cx_q >>> cmd_i.idx;
  assign ta = atan_lut(5'(cmd_i.idx));

  // wrap, round and fold to 1/64 degree
  assign zf   = cz_q[ANG_W-1] ? cz_q + ANG_360 : cz_q;
  assign zr   = zf + ANG_RND;
  assign hraw = zr[AXIS_W+SCALE_SH-1:SCALE_SH];
  assign hfin = (zero_q || hraw >= HEAD_FULL) ? '0 : hraw[HEAD_W-1:0];

  assign diff = (hn_q > shown_q) ? hn_q - shown_q : shown_q - hn_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      shown_q <= '0;
      thr_q   <= HEAD_W'(192);
    end else begin
      if (cfg_we_i) begin
        thr_q <= cfg_data_i;
      end
      if (cmd_i.accept) begin
        pos_q <= launch ? '0 : pos_eff + 1'b1;
      end
      if (cmd_i.emit && diff > thr_q) begin
        shown_q <= hn_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && !launch) begin
      frame_q <= (frame_q & ~(FRAME_W'(8'hFF) << sh)) | (FRAME_W'(data_byte_i) << sh);
    end
    if (launch) begin
      ax_x_q <= frame_q[39:24];
      ax_y_q <= {frame_q[7:0], data_byte_i};
      ax_z_q <= frame_q[23:8];
      zero_q <= (frame_q[39:24] == '0) && ({frame_q[7:0], data_byte_i} == '0);
      if (frame_q[39]) begin
        cx_q <= sx;
        cy_q <= sy;
        cz_q <= ANG_180;
      end else begin
        cx_q <= -sx;
        cy_q <= -sy;
        cz_q <= '0;
      end
    end
    if (cmd_i.step) begin
      if (!cy_q[VEC_W-1]) begin
        cx_q <= cx_q + dx;
        cy_q <= cy_q - dy;
        cz_q <= cz_q + ta;
      end else begin
        cx_q <= cx_q - dx;
        cy_q <= cy_q + dy;
        cz_q <= cz_q - ta;
      end
    end
    if (cmd_i.finish) begin
      hn_q <= hfin;
    end
    if (cmd_i.emit) begin
      mag_x_o         <= nx;
      mag_y_o         <= ny;
      mag_z_o         <= ax_z_q;
      heading_new_o   <= hn_q;
      shown_changed_o <= (diff > thr_q);
      heading_shown_o <= (diff > thr_q) ? hn_q : shown_q;
    end
  end

endmodule

// ===== src/magnetometer_heading_deadband.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// magnetometer_heading_deadband
// Compass heading from big-endian X, Z, Y magnetometer frames, with a
// deadband-filtered shown heading.
// ----------------------------------------------------------------------------
// Bytes 1 to 5 of a frame are taken one per cycle. The sixth byte starts a
// CORDIC vectoring run on one shared add/shift stage, one step per cycle, and
// the input is stalled through the run, the finish step and the hand-off,
// which waits on out_stall_i for the earlier item. One result item comes out
// per completed frame; a high frame_start restarts the frame at that byte.
// The deadband register may be written at any time the block is idle.
// ----------------------------------------------------------------------------
module magnetometer_heading_deadband (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [mhd_pkg::BYTE_W-1:0]        data_byte_i,
  input  logic                              frame_start_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [mhd_pkg::AXIS_W-1:0] mag_x_o,
  output logic signed [mhd_pkg::AXIS_W-1:0] mag_y_o,
  output logic signed [mhd_pkg::AXIS_W-1:0] mag_z_o,
  output logic [mhd_pkg::HEAD_W-1:0]        heading_new_o,
  output logic [mhd_pkg::HEAD_W-1:0]        heading_shown_o,
  output logic                              shown_changed_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [mhd_pkg::HEAD_W-1:0]        cfg_data_i
);
  import mhd_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready_o = 1'b1;

  mhd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  mhd_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .data_byte_i     (data_byte_i),
    .frame_start_i   (frame_start_i),
    .cfg_we_i        (cfg_valid_i && cfg_ready_o),
    .cfg_data_i      (cfg_data_i),
    .mag_x_o         (mag_x_o),
    .mag_y_o         (mag_y_o),
    .mag_z_o         (mag_z_o),
    .heading_new_o   (heading_new_o),
    .heading_shown_o (heading_shown_o),
    .shown_changed_o (shown_changed_o)
  );

endmodule

// ===== src/mhd_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mhd_checker
// Port-level checks on the heading block, bound to the top level.
// ----------------------------------------------------------------------------
module mhd_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_stall_o,
  input logic                              out_valid_o,
  input logic                              out_stall_i,
  input logic signed [mhd_pkg::AXIS_W-1:0] mag_x_o,
  input logic [mhd_pkg::HEAD_W-1:0]        heading_new_o,
  input logic [mhd_pkg::HEAD_W-1:0]        heading_shown_o,
  input logic                              shown_changed_o
);
  import mhd_pkg::*;

  // stalled item holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(heading_new_o)
      && $stable(heading_shown_o) && $stable(mag_x_o))
    else $error("stalled output item changed");

  a_new_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> heading_new_o < HEAD_W'(23040))
    else $error("heading_new out of range");

  a_shown_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> heading_shown_o < HEAD_W'(23040))
    else $error("heading_shown out of range");

  a_changed_eq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && shown_changed_o |-> heading_shown_o == heading_new_o)
    else $error("shown heading did not take new heading");

  // an accepted byte, with no output pending, is not followed by an output in the next cycle
  a_no_instant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && !out_valid_o |=> !out_valid_o)
    else $error("result appeared without compute time");

endmodule

bind magnetometer_heading_deadband mhd_checker u_mhd_checker (.*);

// ===== test/magnetometer_heading_deadband_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// magnetometer_heading_deadband_tb
// Self-checking bench for the compass heading block. Byte items go in on a
// valid/stall channel and frame results are checked field by field against a
// CORDIC heading and deadband predictor kept in step with every accepted
// byte. A short directed table comes first, then random frames over several
// deadband settings, with random idling on both sides in all but the last two
// phases, one long output hold-off and a drain before each register write.
// ----------------------------------------------------------------------------
module magnetometer_heading_deadband_tb;
  import mhd_pkg::*;

  localparam int     WATCHDOG_LIMIT = 5000;
  localparam int     SETTLE_CYCLES  = 40;
  localparam int     HOLD_CYCLES    = 300;
  localparam int     PHASE_ITEMS    = 50;
  localparam int     NUM_PHASES     = 8;
  localparam int     MAX_REPORTS    = 10;
  localparam longint ANG_HALF_TURN  = 2949120;
  localparam longint ANG_FULL_TURN  = 5898240;
  localparam longint HEAD_WRAP      = 23040;
  localparam logic [HEAD_W-1:0] DEADBAND_AT_RESET = HEAD_W'(192);

  // atan(2^-i) in 2^-14 degree
  localparam longint ATAN_STEP [24] = '{
    737280, 435242, 229970, 116736, 58595, 29326, 14667, 7334,
    3667, 1833, 917, 458, 229, 115, 57, 29,
    14, 7, 4, 2, 1, 0, 0, 0
  };

  typedef struct packed {
    logic signed [AXIS_W-1:0] mag_x;
    logic signed [AXIS_W-1:0] mag_y;
    logic signed [AXIS_W-1:0] mag_z;
    logic [HEAD_W-1:0]        heading_new;
    logic [HEAD_W-1:0]        heading_shown;
    logic                     changed;
  } frame_result_t;

  typedef struct packed {
    logic              fs;
    logic [BYTE_W-1:0] data;
    logic              typed;
    frame_result_t     want;
  } byte_row_t;

  typedef enum int {FRAME_CUT, FRAME_UNMARKED, FRAME_NOISY, FRAME_CLEAN} frame_kind_e;

  localparam frame_result_t NO_RESULT = '0;

  localparam byte_row_t DIRECTED [26] = '{
    // zero vector straight after reset
    '{1'b1, 8'h00, 1'b0, NO_RESULT},
    '{1'b0, 8'h00, 1'b0, NO_RESULT},
    '{1'b0, 8'h12, 1'b0, NO_RESULT},
    '{1'b0, 8'h34, 1'b0, NO_RESULT},
    '{1'b0, 8'h00, 1'b0, NO_RESULT},
    '{1'b0, 8'h00, 1'b1, '{16'sh0000, 16'sh0000, 16'sh1234, 15'd0, 15'd0, 1'b0}},
    // most negative x, most positive y and z
    '{1'b1, 8'h80, 1'b0, NO_RESULT},
    '{1'b0, 8'h00, 1'b0, NO_RESULT},
    '{1'b0, 8'h7F, 1'b0, NO_RESULT},
    '{1'b0, 8'hFF, 1'b0, NO_RESULT},
    '{1'b0, 8'h7F, 1'b0, NO_RESULT},
    '{1'b0, 8'hFF, 1'b0, NO_RESULT},
    // partial frame dropped by a restart
    '{1'b1, 8'hAA, 1'b0, NO_RESULT},
    '{1'b0, 8'h55, 1'b0, NO_RESULT},
    '{1'b1, 8'h7F, 1'b0, NO_RESULT},
    '{1'b0, 8'hFF, 1'b0, NO_RESULT},
    '{1'b0, 8'h80, 1'b0, NO_RESULT},
    '{1'b0, 8'h00, 1'b0, NO_RESULT},
    '{1'b0, 8'h80, 1'b0, NO_RESULT},
    '{1'b0, 8'h00, 1'b0, NO_RESULT},
    // unmarked frame, zero vector pulls the shown heading back to zero
    '{1'b0, 8'h00, 1'b0, NO_RESULT},
    '{1'b0, 8'h00, 1'b0, NO_RESULT},
    '{1'b0, 8'hFF, 1'b0, NO_RESULT},
    '{1'b0, 8'hFF, 1'b0, NO_RESULT},
    '{1'b0, 8'h00, 1'b0, NO_RESULT},
    '{1'b0, 8'h00, 1'b1, '{16'sh0000, 16'sh0000, -16'sd1, 15'd0, 15'd0, 1'b1}}
  };

  logic                     clk_i         = 1'b0;
  logic                     rst_ni        = 1'b0;
  logic                     in_valid_i    = 1'b0;
  logic                     in_stall_o;
  logic [BYTE_W-1:0]        data_byte_i   = '0;
  logic                     frame_start_i = 1'b0;
  logic                     out_valid_o;
  logic                     out_stall_i   = 1'b0;
  logic signed [AXIS_W-1:0] mag_x_o;
  logic signed [AXIS_W-1:0] mag_y_o;
  logic signed [AXIS_W-1:0] mag_z_o;
  logic [HEAD_W-1:0]        heading_new_o;
  logic [HEAD_W-1:0]        heading_shown_o;
  logic                     shown_changed_o;
  logic                     cfg_valid_i   = 1'b0;
  logic                     cfg_ready_o;
  logic [HEAD_W-1:0]        cfg_data_i    = '0;

  // predictor state
  logic [POS_W-1:0]   pos_q      = '0;
  logic [FRAME_W-1:0] frame_q    = '0;
  logic [HEAD_W-1:0]  shown_q    = '0;
  logic [HEAD_W-1:0]  deadband_q = DEADBAND_AT_RESET;

  frame_result_t            expected_frames [$];
  int                       mismatches = 0;
  int                       sent_items = 0;
  bit                       idle_on    = 1'b1;
  bit                       hold_req   = 1'b0;
  logic signed [AXIS_W-1:0] last_x     = '0;
  logic signed [AXIS_W-1:0] last_y     = '0;
  logic signed [AXIS_W-1:0] last_z     = '0;

  magnetometer_heading_deadband dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .data_byte_i     (data_byte_i),
    .frame_start_i   (frame_start_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .mag_x_o         (mag_x_o),
    .mag_y_o         (mag_y_o),
    .mag_z_o         (mag_z_o),
    .heading_new_o   (heading_new_o),
    .heading_shown_o (heading_shown_o),
    .shown_changed_o (shown_changed_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i)
  );

  always #2 clk_i = ~clk_i;

  function automatic logic [HEAD_W-1:0] cordic_heading(input logic signed [AXIS_W-1:0] ax,
                                                       input logic signed [AXIS_W-1:0] ay);
    longint x;
    longint y;
    longint z;
    longint dx;
    longint dy;
    longint h;
    if (ax == 0 && ay == 0) begin
      return '0;
    end
    x = longint'(ax) * 256;
    y = longint'(ay) * 256;
    z = 0;
    if (x < 0) begin
      x = -x;
      y = -y;
      z = ANG_HALF_TURN;
    end
    for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx;
        y -= dy;
        z += ATAN_STEP[i];
      end else begin
        x -= dx;
        y += dy;
        z -= ATAN_STEP[i];
      end
    end
    if (z < 0) begin
      z += ANG_FULL_TURN;
    end
    h = (z + 128) >>> 8;
    if (h >= HEAD_WRAP) begin
      h = 0;
    end
    return h[HEAD_W-1:0];
  endfunction

  // advances the frame assembler, returns 1 when the byte closes a frame
  function automatic bit predict_byte(input logic fs, input logic [BYTE_W-1:0] b,
                                      output frame_result_t r);
    logic [POS_W-1:0]  p;
    logic [HEAD_W-1:0] hn;
    logic [HEAD_W-1:0] diff;
    r = '0;
    p = fs ? '0 : pos_q;
    if (p > LAST_POS) begin
      p = '0;
    end
    if (p < LAST_POS) begin
      frame_q[(4 - int'(p)) * 8 +: 8] = b;
      pos_q = p + 1'b1;
      return 1'b0;
    end
    pos_q   = '0;
    r.mag_x = frame_q[39:24];
    r.mag_z = frame_q[23:8];
    r.mag_y = {frame_q[7:0], b};
    hn      = cordic_heading(r.mag_x, r.mag_y);
    diff    = (hn > shown_q) ? hn - shown_q : shown_q - hn;
    if (diff > deadband_q) begin
      shown_q   = hn;
      r.changed = 1'b1;
    end
    r.heading_new   = hn;
    r.heading_shown = shown_q;
    return 1'b1;
  endfunction

  function automatic logic signed [AXIS_W-1:0] pick_axis(input logic signed [AXIS_W-1:0] prev);
    logic signed [AXIS_W-1:0] v;
    case ($urandom_range(0, 3))
      0: v = AXIS_W'($urandom);
      1: begin
        case ($urandom_range(0, 4))
          0:       v = 16'sh0000;
          1:       v = 16'sh0001;
          2:       v = -16'sd1;
          3:       v = 16'sh7FFF;
          default: v = 16'sh8000;
        endcase
      end
      2: v = AXIS_W'(int'($urandom_range(0, 128)) - 64);
      // small drift, within 3 of the previous value on each axis
      default: v = prev + AXIS_W'(int'($urandom_range(0, 6)) - 3);
    endcase
    return v;
  endfunction

  task automatic feed_byte(input logic fs, input logic [BYTE_W-1:0] b, input logic typed,
                           input frame_result_t typed_res);
    frame_result_t r;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    data_byte_i   <= b;
    frame_start_i <= fs;
    do @(posedge clk_i); while (in_stall_o);
    sent_items++;
    if (predict_byte(fs, b, r)) begin
      expected_frames.push_back(typed ? typed_res : r);
    end
  endtask

  // register writes only once the block has drained
  task automatic write_deadband(input logic [HEAD_W-1:0] v);
    in_valid_i <= 1'b0;
    while (expected_frames.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    deadband_q = v;
  endtask

  initial begin
    logic [BYTE_W-1:0] fb [6];
    logic [HEAD_W-1:0] thr;
    frame_kind_e       kind;
    int                pick;
    int                nbytes;
    int                target;
    logic              fs;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DIRECTED[r]) begin
      feed_byte(DIRECTED[r].fs, DIRECTED[r].data, DIRECTED[r].typed, DIRECTED[r].want);
    end

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0:       thr = '0;
        1:       thr = HEAD_W'(23040);
        2:       thr = HEAD_W'(23039);
        3:       thr = HEAD_W'(9216);
        4:       thr = HEAD_W'(1);
        5:       thr = HEAD_W'($urandom_range(0, 512));
        6:       thr = HEAD_W'($urandom_range(0, 23040));
        default: thr = DEADBAND_AT_RESET;
      endcase
      write_deadband(thr);
      idle_on = (ph < NUM_PHASES - 2);
      if (ph == 2) begin
        hold_req = 1'b1;
      end
      target = sent_items + PHASE_ITEMS;
      while (sent_items < target) begin
        last_x = pick_axis(last_x);
        last_z = pick_axis(last_z);
        last_y = pick_axis(last_y);
        fb = '{last_x[15:8], last_x[7:0], last_z[15:8], last_z[7:0], last_y[15:8], last_y[7:0]};
        pick = $urandom_range(0, 9);
        kind = (pick == 0) ? FRAME_CUT : (pick == 1) ? FRAME_UNMARKED :
               (pick == 2) ? FRAME_NOISY : FRAME_CLEAN;
        nbytes = (kind == FRAME_CUT) ? int'($urandom_range(1, 5)) : 6;
        for (int k = 0; k < nbytes; k++) begin
          case (kind)
            FRAME_UNMARKED: fs = 1'b0;
            FRAME_NOISY:    fs = ($urandom_range(0, 3) == 0);
            default:        fs = (k == 0);
          endcase
          feed_byte(fs, fb[k], 1'b0, NO_RESULT);
        end
      end
    end

    in_valid_i <= 1'b0;
    while (expected_frames.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        // long hold-off so the block backs up into its input
        hold_req = 1'b0;
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 13)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    frame_result_t got;
    frame_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = '{mag_x_o, mag_y_o, mag_z_o, heading_new_o, heading_shown_o, shown_changed_o};
      if (expected_frames.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("unexpected result: x %0d y %0d z %0d new %0d shown %0d changed %0b",
                   got.mag_x, got.mag_y, got.mag_z, got.heading_new, got.heading_shown,
                   got.changed);
        end
      end else begin
        want = expected_frames.pop_front();
        if (got.mag_x !== want.mag_x || got.mag_y !== want.mag_y ||
            got.mag_z !== want.mag_z || got.heading_new !== want.heading_new ||
            got.heading_shown !== want.heading_shown || got.changed !== want.changed) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("mismatch: exp x %0d y %0d z %0d new %0d shown %0d changed %0b",
                     want.mag_x, want.mag_y, want.mag_z, want.heading_new,
                     want.heading_shown, want.changed);
            $display("          got x %0d y %0d z %0d new %0d shown %0d changed %0b",
                     got.mag_x, got.mag_y, got.mag_z, got.heading_new,
                     got.heading_shown, got.changed);
          end
        end
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("FAIL");
    $finish;
  end

endmodule
